// ===== rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg
// Shared widths, register indexes and reset values of the box transform.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_SH = 12;
    localparam int QUOT_W  = SUM_W - FRAC_SH;
    localparam int RES_W   = QUOT_W + 1;
    localparam int IDX_W   = 3;
    localparam int AXES    = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X = 3'd0,
        REG_ROW_Y = 3'd1,
        REG_ROW_Z = 3'd2,
        REG_OFF_X = 3'd3,
        REG_OFF_Y = 3'd4,
        REG_OFF_Z = 3'd5
    } t_reg_idx;

    localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(4096);
    localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(4096) << COEF_W;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(4096) << (2 * COEF_W);

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/aat_ifs.sv =====
// ----------------------------------------------------------------------------
// aat channel interfaces
// Input box, output box and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface aat_box_in_if
    import aat_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aat_box_out_if
    import aat_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] new_lo_x;
    logic signed [COORD_W-1:0] new_lo_y;
    logic signed [COORD_W-1:0] new_lo_z;
    logic signed [COORD_W-1:0] new_hi_x;
    logic signed [COORD_W-1:0] new_hi_y;
    logic signed [COORD_W-1:0] new_hi_z;
    logic                      clipped;

    modport source (output valid, new_lo_x, new_lo_y, new_lo_z,
                    new_hi_x, new_hi_y, new_hi_z, clipped, input ready);
    modport sink   (input valid, new_lo_x, new_lo_y, new_lo_z,
                    new_hi_x, new_hi_y, new_hi_z, clipped, output ready);
endinterface

interface aat_cfg_if
    import aat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [ROW_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Maps an axis-aligned box through a 3x3 Q4.12 matrix plus Q16.16 offset and
// returns the box spanned by the eight mapped corners, saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  i_box    | in  | lo_x lo_y lo_z hi_x hi_y hi_z
//  o_box    | out | new_lo_x .. new_hi_z, clipped
//  i_cfg    | in  | index, data (always ready)
//
//  One item per cycle while the output is taken; four pipeline register stages
//  (multiply, pair min/max, row sum, shift/offset/saturate).
//  Each stage holds while the next one is full and stalled, so bubbles fill.
//  Reset (i_rst_n low, synchronous) empties the pipe and restores identity.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform
    import aat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    aat_box_in_if.sink    i_box,
    aat_box_out_if.source o_box,
    aat_cfg_if.sink       i_cfg
);

    logic        [ROW_W-1:0]   r_row [AXES];
    logic signed [COORD_W-1:0] r_off [AXES];

    logic signed [COORD_W-1:0] w_lo [AXES];
    logic signed [COORD_W-1:0] w_hi [AXES];

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic                      w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [PROD_W-1:0]  r_plo  [AXES][AXES];
    logic signed [PROD_W-1:0]  r_phi  [AXES][AXES];
    logic signed [PROD_W-1:0]  r_pmin [AXES][AXES];
    logic signed [PROD_W-1:0]  r_pmax [AXES][AXES];
    logic signed [SUM_W-1:0]   r_smin [AXES];
    logic signed [SUM_W-1:0]   r_smax [AXES];
    logic signed [COORD_W-1:0] r_omin [AXES];
    logic signed [COORD_W-1:0] r_omax [AXES];
    logic                      r_clip;

    logic signed [RES_W-1:0]   n_rmin [AXES];
    logic signed [RES_W-1:0]   n_rmax [AXES];
    logic signed [COORD_W-1:0] n_omin [AXES];
    logic signed [COORD_W-1:0] n_omax [AXES];
    logic                      n_clip;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_X_RESET;
            r_row[1] <= ROW_Y_RESET;
            r_row[2] <= ROW_Z_RESET;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ROW_X: r_row[0] <= i_cfg.data;
                REG_ROW_Y: r_row[1] <= i_cfg.data;
                REG_ROW_Z: r_row[2] <= i_cfg.data;
                REG_OFF_X: r_off[0] <= i_cfg.data[COORD_W-1:0];
                REG_OFF_Y: r_off[1] <= i_cfg.data[COORD_W-1:0];
                REG_OFF_Z: r_off[2] <= i_cfg.data[COORD_W-1:0];
                default:   ;
            endcase
        end
    end

    assign w_lo[0] = i_box.lo_x;
    assign w_lo[1] = i_box.lo_y;
    assign w_lo[2] = i_box.lo_z;
    assign w_hi[0] = i_box.hi_x;
    assign w_hi[1] = i_box.hi_y;
    assign w_hi[2] = i_box.hi_z;

    assign w_rdy4      = !r_v4 || o_box.ready;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_box.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_box.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // products of every coefficient with both ends of its input axis
    always_ff @(posedge i_clk) begin
        if (i_box.valid && w_rdy1) begin
            for (int a = 0; a < AXES; a++) begin
                for (int j = 0; j < AXES; j++) begin
                    r_plo[a][j] <= $signed(r_row[a][j*COEF_W +: COEF_W]) * w_lo[j];
                    r_phi[a][j] <= $signed(r_row[a][j*COEF_W +: COEF_W]) * w_hi[j];
                end
            end
        end
    end

    // floor, offset and clamp are monotone, so the extremes come from
    // the smallest and largest term per coefficient
    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            for (int a = 0; a < AXES; a++) begin
                for (int j = 0; j < AXES; j++) begin
                    if (r_plo[a][j] < r_phi[a][j]) begin
                        r_pmin[a][j] <= r_plo[a][j];
                        r_pmax[a][j] <= r_phi[a][j];
                    end else begin
                        r_pmin[a][j] <= r_phi[a][j];
                        r_pmax[a][j] <= r_plo[a][j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            for (int a = 0; a < AXES; a++) begin
                r_smin[a] <= SUM_W'(r_pmin[a][0]) + SUM_W'(r_pmin[a][1])
                           + SUM_W'(r_pmin[a][2]);
                r_smax[a] <= SUM_W'(r_pmax[a][0]) + SUM_W'(r_pmax[a][1])
                           + SUM_W'(r_pmax[a][2]);
            end
        end
    end

    always_comb begin
        n_clip = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            n_rmin[a] = RES_W'($signed(r_smin[a][SUM_W-1:FRAC_SH])) + RES_W'(r_off[a]);
            n_rmax[a] = RES_W'($signed(r_smax[a][SUM_W-1:FRAC_SH])) + RES_W'(r_off[a]);
            n_omin[a] = n_rmin[a][COORD_W-1:0];
            n_omax[a] = n_rmax[a][COORD_W-1:0];
            if (n_rmin[a] > RES_W'(SAT_MAX)) begin
                n_omin[a] = SAT_MAX;
                n_clip    = 1'b1;
            end else if (n_rmin[a] < RES_W'(SAT_MIN)) begin
                n_omin[a] = SAT_MIN;
                n_clip    = 1'b1;
            end
            if (n_rmax[a] > RES_W'(SAT_MAX)) begin
                n_omax[a] = SAT_MAX;
                n_clip    = 1'b1;
            end else if (n_rmax[a] < RES_W'(SAT_MIN)) begin
                n_omax[a] = SAT_MIN;
                n_clip    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_rdy4) begin
            r_omin <= n_omin;
            r_omax <= n_omax;
            r_clip <= n_clip;
        end
    end

    assign o_box.valid    = r_v4;
    assign o_box.new_lo_x = r_omin[0];
    assign o_box.new_lo_y = r_omin[1];
    assign o_box.new_lo_z = r_omin[2];
    assign o_box.new_hi_x = r_omax[0];
    assign o_box.new_hi_y = r_omax[1];
    assign o_box.new_hi_z = r_omax[2];
    assign o_box.clipped  = r_clip;

`ifndef SYNTHESIS
    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> (o_box.new_lo_x <= o_box.new_hi_x) &&
                        (o_box.new_lo_y <= o_box.new_hi_y) &&
                        (o_box.new_lo_z <= o_box.new_hi_z))
        else $error("output box inverted");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_box.valid && !r_v1 && !r_v2 && !r_v3)
        else $error("pipe not empty after reset");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !o_box.ready) |-> !i_box.ready)
        else $error("input taken while pipe is full and stalled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !o_box.ready) |=> r_v3)
        else $error("stage three item lost during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/aabb_affine_transform_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb
// Sends boxes through the transform under a series of matrix and offset
// settings (identity, both saturating extremes, zero matrix, random maps).
// Each accepted box is mapped by a bench-side predictor. Every output item is
// compared field by field with the oldest prediction. Both channels stall at
// random, but for the last three phases, which run without stalls.
// ----------------------------------------------------------------------------
module aabb_affine_transform_tb;
    import aat_pkg::*;

    localparam int PIPE_LAT    = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 56;

    localparam logic [IDX_W-1:0]  IDX_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0]  IDX_SPARE_HI = 3'd7;
    localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7fff;
    localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;

    typedef logic [AXES-1:0][COORD_W-1:0] t_vec;
    typedef struct packed {
        t_vec lo;
        t_vec hi;
    } t_box;
    typedef struct packed {
        t_vec lo;
        t_vec hi;
        logic clipped;
    } t_bound;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             box_valid = 1'b0;
    t_box             box_data  = '0;
    logic             res_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data  = '0;

    logic [ROW_W-1:0]   row_reg [AXES];
    logic [COORD_W-1:0] off_reg [AXES];

    t_box   box_q   [$];
    t_bound bound_q [$];

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;
    int quiet_cycles = 0;
    int send_idle    = 11;
    int recv_idle    = 75;
    bit in_fire      = 1'b0;

    aat_box_in_if  box_if ();
    aat_box_out_if res_if ();
    aat_cfg_if     cfg_if ();

    assign box_if.valid = box_valid;
    assign box_if.lo_x  = box_data.lo[0];
    assign box_if.lo_y  = box_data.lo[1];
    assign box_if.lo_z  = box_data.lo[2];
    assign box_if.hi_x  = box_data.hi[0];
    assign box_if.hi_y  = box_data.hi[1];
    assign box_if.hi_z  = box_data.hi[2];
    assign res_if.ready = res_ready;
    assign cfg_if.valid = cfg_valid;
    assign cfg_if.index = cfg_index;
    assign cfg_if.data  = cfg_data;

    aabb_affine_transform dut (
        .i_clk,
        .i_rst_n,
        .i_box (box_if),
        .o_box (res_if),
        .i_cfg (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // mapped box: floor(row . p / 4096) + offset per corner, clamped, then min/max
    function automatic t_bound map_box(input t_box b);
        t_bound                    r;
        logic signed [COORD_W-1:0] pt [AXES];
        logic signed [COEF_W-1:0]  coef;
        logic signed [COORD_W-1:0] off;
        longint                    acc;
        longint                    v;
        longint                    mn [AXES];
        longint                    mx [AXES];
        r = '0;
        for (int c = 0; c < 8; c++) begin
            for (int a = 0; a < AXES; a++)
                pt[a] = ((c >> a) & 1) ? b.hi[a] : b.lo[a];
            for (int a = 0; a < AXES; a++) begin
                acc = 0;
                for (int j = 0; j < AXES; j++) begin
                    coef = row_reg[a][COEF_W*j +: COEF_W];
                    acc += longint'(coef) * longint'(pt[j]);
                end
                off = off_reg[a];
                v = (acc >>> FRAC_SH) + longint'(off);
                if (v > longint'(SAT_MAX)) begin
                    v = SAT_MAX;
                    r.clipped = 1'b1;
                end else if (v < longint'(SAT_MIN)) begin
                    v = SAT_MIN;
                    r.clipped = 1'b1;
                end
                if (c == 0 || v < mn[a])
                    mn[a] = v;
                if (c == 0 || v > mx[a])
                    mx[a] = v;
            end
        end
        for (int a = 0; a < AXES; a++) begin
            r.lo[a] = mn[a][COORD_W-1:0];
            r.hi[a] = mx[a][COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_box mk_box(input logic [COORD_W-1:0] lx, ly, lz, hx, hy, hz);
        t_box b;
        b.lo = {lz, ly, lx};
        b.hi = {hz, hy, hx};
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3, 4: return $urandom();
            default: return COORD_W'($urandom_range(32'h00ff_ffff)) - 32'h0080_0000;
        endcase
    endfunction

    function automatic t_box rand_box();
        t_box b;
        for (int a = 0; a < AXES; a++) begin
            b.lo[a] = rand_coord();
            if ($urandom_range(9) == 0)
                b.hi[a] = rand_coord();
            else
                b.hi[a] = b.lo[a] + ($urandom() >> $urandom_range(31));
        end
        return b;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(4))
            0: return COEF_W'($urandom());
            1: return '0;
            default: return COEF_W'($urandom_range(16384)) - 16'h2000;
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // upper 16 bits of an offset word are junk and must be dropped
    function automatic logic [ROW_W-1:0] rand_offset();
        logic [COORD_W-1:0] off;
        if ($urandom_range(1))
            off = $urandom();
        else
            off = COORD_W'($urandom_range(32'h001f_ffff)) - 32'h0010_0000;
        return {16'($urandom()), off};
    endfunction

    function automatic void push_box(input t_box b);
        box_q.push_back(b);
        pushed_cnt++;
    endfunction

    function automatic void push_edge_boxes();
        push_box(mk_box('0, '0, '0, '0, '0, '0));
        push_box(mk_box('1, '1, '1, 32'd1, 32'd1, 32'd1));
        push_box(mk_box(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX));
        push_box(mk_box(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN));
        push_box(mk_box(32'h0001_8000, 32'hffff_7fff, 32'h0000_0001,
                        32'h0002_0000, 32'h0000_7fff, 32'h0000_0fff));
        push_box(mk_box(32'haaaa_5555, 32'h5555_aaaa, 32'haaaa_5555,
                        32'h5555_aaaa, 32'haaaa_5555, 32'h5555_aaaa));
    endfunction

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_reg[idx] = value;
            REG_OFF_X, REG_OFF_Y, REG_OFF_Z: off_reg[idx - REG_OFF_X] = value[COORD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_map(input logic [ROW_W-1:0] rx, ry, rz, ox, oy, oz);
        cfg_write(REG_ROW_X, rx);
        cfg_write(REG_ROW_Y, ry);
        cfg_write(REG_ROW_Z, rz);
        cfg_write(REG_OFF_X, ox);
        cfg_write(REG_OFF_Y, oy);
        cfg_write(REG_OFF_Z, oz);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (accepted_cnt != pushed_cnt || bound_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // driver: box source and result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            box_valid <= 1'b0;
            res_ready <= 1'b0;
        end else begin
            if ((!box_valid || in_fire) && box_q.size() != 0
                    && $urandom_range(99) >= send_idle) begin
                box_valid <= 1'b1;
                box_data  <= box_q.pop_front();
            end else if (in_fire) begin
                box_valid <= 1'b0;
            end
            res_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: predict on input accept, check on output accept, watchdog
    always @(posedge i_clk) begin : monitor
        t_bound got;
        t_bound want;
        bit     out_fire;
        in_fire  = box_valid && box_if.ready;
        out_fire = res_if.valid && res_ready;
        if (in_fire) begin
            bound_q.push_back(map_box(box_data));
            accepted_cnt++;
        end
        if (out_fire) begin
            got.lo      = {res_if.new_lo_z, res_if.new_lo_y, res_if.new_lo_x};
            got.hi      = {res_if.new_hi_z, res_if.new_hi_y, res_if.new_hi_x};
            got.clipped = res_if.clipped;
            if (bound_q.size() == 0) begin
                $display("%0t unexpected item: expected none actual lo %h hi %h clipped %b",
                         $time, got.lo, got.hi, got.clipped);
                fail_cnt++;
            end else begin
                want = bound_q.pop_front();
                for (int a = 0; a < AXES; a++) begin
                    if (got.lo[a] !== want.lo[a]) begin
                        $display("%0t new_lo axis %0d: expected %h actual %h",
                                 $time, a, want.lo[a], got.lo[a]);
                        fail_cnt++;
                    end
                    if (got.hi[a] !== want.hi[a]) begin
                        $display("%0t new_hi axis %0d: expected %h actual %h",
                                 $time, a, want.hi[a], got.hi[a]);
                        fail_cnt++;
                    end
                end
                if (got.clipped !== want.clipped) begin
                    $display("%0t clipped: expected %b actual %b",
                             $time, want.clipped, got.clipped);
                    fail_cnt++;
                end
            end
        end
        if (in_fire || out_fire || (cfg_valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        row_reg[0] = ROW_X_RESET;
        row_reg[1] = ROW_Y_RESET;
        row_reg[2] = ROW_Z_RESET;
        for (int a = 0; a < AXES; a++)
            off_reg[a] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity map out of reset
        push_edge_boxes();
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle = 11;
                    recv_idle = 75;
                end
                1: begin
                    send_idle = 75;
                    recv_idle = 11;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (p)
                0: begin
                    cfg_write(IDX_SPARE_LO, {16'($urandom()), 32'($urandom())});
                    cfg_write(IDX_SPARE_HI, {16'($urandom()), 32'($urandom())});
                    load_map({3{COEF_POS_MAX}}, {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}},
                             {16'hffff, SAT_MAX}, {16'hffff, SAT_MAX}, {16'hffff, SAT_MAX});
                end
                1: load_map({3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}},
                            {16'h0000, SAT_MIN}, {16'h5a5a, SAT_MIN}, {16'hffff, SAT_MIN});
                2: load_map('0, '0, '0, rand_offset(), rand_offset(), rand_offset());
                3: load_map(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET,
                            rand_offset(), rand_offset(), rand_offset());
                default: load_map(rand_row(), rand_row(), rand_row(),
                                  rand_offset(), rand_offset(), rand_offset());
            endcase
            if (p < 2)
                push_edge_boxes();
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_box(rand_box());
            drain();
        end

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/aat_pkg.sv
rtl/aat_ifs.sv
rtl/aabb_affine_transform.sv
tb/aabb_affine_transform_tb.sv
